// ===== hdl/tvbm_pkg.sv =====
// Shared types and constants for the thin volume block mapper.
package tvbm_pkg;

  localparam int EXT_W  = 12;
  localparam int BLK_W  = 8;
  localparam int VB_W   = EXT_W + BLK_W;
  localparam int SNAP_W = 16;
  localparam int VEXT_W = 13;
  localparam int OFS_W  = 24;
  localparam int POS_W  = 32;
  localparam int CNT_W  = 9;
  localparam int ADDR_W = 40;
  localparam int BLOCKS_PER_EXTENT = 256;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_UNMAP = 2'd2;

  localparam logic [1:0] REG_SNAPSHOT = 2'd0;
  localparam logic [1:0] REG_VOL_EXT  = 2'd1;
  localparam logic [1:0] REG_OFFSET   = 2'd2;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_UNMAP,
    CMD_NOP,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]      action;
    logic [VB_W-1:0] volume_block;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic              mapped;
    logic [ADDR_W-1:0] device_block;
    logic              extent_allocated;
    logic              extent_released;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [EXT_W-1:0] ext;
    logic [BLK_W-1:0] blk;
  } cmd_t;

  typedef struct packed {
    logic [SNAP_W-1:0] current_snapshot;
    logic [VEXT_W-1:0] volume_extents;
    logic [OFS_W-1:0]  data_offset_blocks;
  } cfg_t;

endpackage

// ===== hdl/tvbm_front.sv =====
// Front end: accepts items, classifies them and queues commands for the back end.
module tvbm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  tvbm_pkg::in_item_t  in_item,
  input  logic                busy,
  input  logic [tvbm_pkg::VEXT_W-1:0] volume_extents,
  output logic                cmd_valid,
  output tvbm_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);

  tvbm_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push;
  tvbm_pkg::cmd_t cls;
  logic [tvbm_pkg::EXT_W-1:0] ext;

  assign ext = in_item.volume_block[tvbm_pkg::VB_W-1:tvbm_pkg::BLK_W];

  always_comb begin
    cls.ext = ext;
    cls.blk = in_item.volume_block[tvbm_pkg::BLK_W-1:0];
    if (in_item.action != tvbm_pkg::ACT_READ && in_item.action != tvbm_pkg::ACT_WRITE &&
        in_item.action != tvbm_pkg::ACT_UNMAP) begin
      cls.kind = tvbm_pkg::CMD_NOP;
    end else if ({1'b0, ext} >= volume_extents) begin
      cls.kind = tvbm_pkg::CMD_REJECT;
    end else if (in_item.action == tvbm_pkg::ACT_READ) begin
      cls.kind = tvbm_pkg::CMD_READ;
    end else if (in_item.action == tvbm_pkg::ACT_WRITE) begin
      cls.kind = tvbm_pkg::CMD_WRITE;
    end else begin
      cls.kind = tvbm_pkg::CMD_UNMAP;
    end
  end

  assign in_full   = (cnt_r == 2'd2) || busy;
  assign push      = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(cmd_pop && cmd_valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && cmd_pop && cmd_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (cmd_pop && cmd_valid) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// ===== hdl/tvbm_back.sv =====
// Back end: extent table, bitmap memory, command execution and result queue.
module tvbm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tvbm_pkg::cfg_t       cfg,
  input  logic                 cmd_valid,
  input  tvbm_pkg::cmd_t       cmd,
  output logic                 cmd_pop,
  output logic                 busy,
  output logic                 out_empty,
  input  logic                 out_pop,
  output tvbm_pkg::out_item_t  out_item
);

  typedef struct packed {
    logic [tvbm_pkg::SNAP_W-1:0] owner;
    logic [tvbm_pkg::POS_W-1:0]  pos;
    logic [tvbm_pkg::CNT_W-1:0]  cnt;
  } meta_t;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  localparam int NEXT = 1 << tvbm_pkg::EXT_W;

  meta_t meta_mem [NEXT];
  logic [tvbm_pkg::BLOCKS_PER_EXTENT-1:0] map_mem [NEXT];

  state_t state_r;
  logic [tvbm_pkg::EXT_W-1:0] clr_r;
  tvbm_pkg::cmd_t cmd_r;
  meta_t meta_rd_r;
  logic [tvbm_pkg::BLOCKS_PER_EXTENT-1:0] map_rd_r;
  logic [tvbm_pkg::POS_W-1:0] ctr_r;

  tvbm_pkg::out_item_t oq_r [2];
  logic [1:0] ocnt_r;
  logic owp_r, orp_r;

  meta_t meta_wd;
  logic  meta_we;
  logic [tvbm_pkg::EXT_W-1:0] meta_wa;
  logic [tvbm_pkg::BLOCKS_PER_EXTENT-1:0] map_wd;
  logic  map_we;
  logic  alloc, hit, res_push, do_pop;
  logic [tvbm_pkg::CNT_W-1:0] cnt_dec;
  logic [tvbm_pkg::POS_W-1:0] pos_use;
  tvbm_pkg::out_item_t res;

  assign busy      = (state_r == S_CLEAR);
  assign do_pop    = (state_r == S_IDLE) && cmd_valid && (ocnt_r != 2'd2);
  assign cmd_pop   = do_pop;
  assign out_empty = (ocnt_r == 2'd0);
  assign out_item  = oq_r[orp_r];
  assign res_push  = (state_r == S_EXEC);

  assign hit     = (meta_rd_r.owner != '0) && map_rd_r[cmd_r.blk];
  assign alloc   = (meta_rd_r.owner == '0) || (meta_rd_r.owner != cfg.current_snapshot);
  assign cnt_dec = (meta_rd_r.cnt != '0) ? meta_rd_r.cnt - 1'b1 : meta_rd_r.cnt;
  assign pos_use = alloc ? ctr_r : meta_rd_r.pos;

  always_comb begin
    meta_we = 1'b0;
    map_we  = 1'b0;
    meta_wa = cmd_r.ext;
    meta_wd = meta_rd_r;
    map_wd  = map_rd_r;
    res     = '0;
    if (state_r == S_CLEAR) begin
      meta_we = 1'b1;
      meta_wa = clr_r;
      meta_wd = '0;
    end else if (state_r == S_EXEC) begin
      case (cmd_r.kind)
        tvbm_pkg::CMD_REJECT: begin
          res.status = 1'b1;
        end
        tvbm_pkg::CMD_READ: begin
          if (hit) begin
            res.mapped       = 1'b1;
            res.device_block = {meta_rd_r.pos, cmd_r.blk}
                               + {{(tvbm_pkg::ADDR_W-tvbm_pkg::OFS_W){1'b0}},
                                  cfg.data_offset_blocks};
          end
        end
        tvbm_pkg::CMD_WRITE: begin
          meta_we = 1'b1;
          map_we  = 1'b1;
          if (alloc) begin
            meta_wd.owner = cfg.current_snapshot;
            meta_wd.pos   = ctr_r;
            meta_wd.cnt   = tvbm_pkg::CNT_W'(1);
            map_wd        = '0;
            map_wd[cmd_r.blk] = 1'b1;
          end else if (!map_rd_r[cmd_r.blk]) begin
            meta_wd.cnt   = meta_rd_r.cnt + 1'b1;
            map_wd[cmd_r.blk] = 1'b1;
          end
          res.mapped           = 1'b1;
          res.extent_allocated = alloc;
          res.device_block     = {pos_use, cmd_r.blk}
                                 + {{(tvbm_pkg::ADDR_W-tvbm_pkg::OFS_W){1'b0}},
                                    cfg.data_offset_blocks};
        end
        tvbm_pkg::CMD_UNMAP: begin
          if (hit) begin
            meta_we = 1'b1;
            map_we  = 1'b1;
            map_wd[cmd_r.blk] = 1'b0;
            meta_wd.cnt = cnt_dec;
            if (cnt_dec == '0) begin
              meta_wd.owner       = '0;
              res.extent_released = 1'b1;
            end
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ctr_r   <= '0;
      ocnt_r  <= 2'd0;
      owp_r   <= 1'b0;
      orp_r   <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == {tvbm_pkg::EXT_W{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (do_pop) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          if (cmd_r.kind == tvbm_pkg::CMD_WRITE && alloc) begin
            ctr_r <= ctr_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (res_push) begin
        owp_r <= ~owp_r;
      end
      if (out_pop && !out_empty) begin
        orp_r <= ~orp_r;
      end
      if (res_push && !(out_pop && !out_empty)) begin
        ocnt_r <= ocnt_r + 2'd1;
      end else if (!res_push && out_pop && !out_empty) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      cmd_r <= cmd;
    end
    meta_rd_r <= meta_mem[cmd.ext];
    map_rd_r  <= map_mem[cmd.ext];
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    if (map_we) begin
      map_mem[cmd_r.ext] <= map_wd;
    end
    if (res_push) begin
      oq_r[owp_r] <= res;
    end
  end

endmodule

// ===== hdl/thin_volume_block_mapper_top.sv =====
// Top level of the thin volume block mapper: register port and the two halves.
//
// Each item (read, write or unmap of one volume block) passes two back-end
// states: idle, where its pop reads the extent's table entry and bitmap row,
// and execute, which updates them and queues the result; no new item is taken
// until the back end is idle again. Items are queued two deep ahead of the back
// end and results two deep behind it. After reset the extent table is cleared,
// during which in_full stays high; register writes are taken as ever.
module thin_volume_block_mapper_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  tvbm_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output tvbm_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  tvbm_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic           busy, cmd_valid, cmd_pop;
  tvbm_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_snapshot   <= tvbm_pkg::SNAP_W'(1);
      cfg_r.volume_extents     <= tvbm_pkg::VEXT_W'(4096);
      cfg_r.data_offset_blocks <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        tvbm_pkg::REG_SNAPSHOT: cfg_r.current_snapshot   <= pwdata[tvbm_pkg::SNAP_W-1:0];
        tvbm_pkg::REG_VOL_EXT:  cfg_r.volume_extents     <= pwdata[tvbm_pkg::VEXT_W-1:0];
        tvbm_pkg::REG_OFFSET:   cfg_r.data_offset_blocks <= pwdata[tvbm_pkg::OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tvbm_pkg::REG_SNAPSHOT: prdata = {16'd0, cfg_r.current_snapshot};
      tvbm_pkg::REG_VOL_EXT:  prdata = {19'd0, cfg_r.volume_extents};
      tvbm_pkg::REG_OFFSET:   prdata = {8'd0, cfg_r.data_offset_blocks};
      default:                prdata = 32'd0;
    endcase
  end

  tvbm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_item        (in_item),
    .busy           (busy),
    .volume_extents (cfg_r.volume_extents),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  tvbm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .busy      (busy),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
